[src/hex_grid_pick_index_assert.svh]
// Assertion macros for the hex grid pick index checker.
// Both macros expect aclk and aresetn to exist in the scope where they are used.
`ifndef HEX_GRID_PICK_INDEX_ASSERT_SVH
`define HEX_GRID_PICK_INDEX_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while reset is asserted
`define HGPI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("hex_grid_pick_index: same-cycle check failed");

// Next-cycle implication, sampled on aclk, off while reset is asserted
`define HGPI_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("hex_grid_pick_index: next-cycle check failed");

`endif

[src/hgpi_pkg.sv]
// Shared types, constants and helpers for the hex grid pick index block.
// No dependencies; every module of the block imports this package.
`default_nettype none

package hgpi_pkg;

    // Field widths
    localparam int POS_W    = 16;
    localparam int INV_W    = 16;
    localparam int HEX_W    = 13;
    localparam int IDX_W    = 6;

    // Internal widths
    localparam int PROD_W   = 32;   // position times Q0.16 constant
    localparam int FRAC_W   = 48;   // scaled coordinate after the second multiply
    localparam int CUBE_W   = 49;   // cube coordinate, holds -x - z
    localparam int FRAC_BITS = 36;
    localparam int RND_W    = CUBE_W - FRAC_BITS + 1;
    localparam int AXIAL_W  = RND_W + 1;

    // Default board radius and register reset value
    localparam int RADIUS_DEF = 4;
    localparam logic [INV_W-1:0] INV_RESET = INV_W'(2185);

    // Q0.16 constants: sqrt(3)/3, 1/3, 2/3 (signed, so products stay signed)
    localparam logic signed [INV_W:0] K_SQRT3_3    = 17'sd37837;
    localparam logic signed [INV_W:0] K_THIRD      = 17'sd21845;
    localparam logic signed [INV_W:0] K_TWO_THIRDS = 17'sd43691;

    // Saturation limits for the axial outputs
    localparam logic signed [AXIAL_W-1:0] HEX_MIN = -(AXIAL_W'(4096));
    localparam logic signed [AXIAL_W-1:0] HEX_MAX = AXIAL_W'(4095);

    // Load strobes for the two multiplier stages
    typedef struct packed {
        logic ld0;
        logic ld1;
    } hgpi_mul_ctl_t;

    // Rounded coordinate and its rounding error (36 fraction bits)
    typedef struct packed {
        logic signed [RND_W-1:0]  rnd;
        logic [FRAC_BITS-1:0]     err;
    } hgpi_round_t;

    // Saturate an axial coordinate to the output range
    function automatic logic signed [HEX_W-1:0] sat_hex(input logic signed [AXIAL_W-1:0] v);
        logic signed [AXIAL_W-1:0] c;
        begin
            c = (v < HEX_MIN) ? HEX_MIN : ((v > HEX_MAX) ? HEX_MAX : v);
            return c[HEX_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

[src/hgpi_mult.sv]
// Two multiplier stages: position times Q0.16 constants, then times the register.
// Depends on hgpi_pkg.
`default_nettype none

module hgpi_mult (
    input  wire logic                                  aclk,
    input  wire hgpi_pkg::hgpi_mul_ctl_t               ctl,
    input  wire logic signed [hgpi_pkg::POS_W-1:0]     pos_x,
    input  wire logic signed [hgpi_pkg::POS_W-1:0]     pos_y,
    input  wire logic [hgpi_pkg::INV_W-1:0]            inv,
    output logic signed [hgpi_pkg::FRAC_W-1:0]         frac_x,
    output logic signed [hgpi_pkg::FRAC_W-1:0]         frac_z
);
    import hgpi_pkg::*;

    logic signed [PROD_W-1:0]  px_k_reg, py_k_reg, py_k2_reg;
    logic signed [PROD_W-1:0]  px_k_next, py_k_next, py_k2_next;
    logic signed [PROD_W:0]    diff;
    logic signed [INV_W:0]     inv_s;
    logic signed [FRAC_W-1:0]  fx_reg, fz_reg, fx_next, fz_next;

    // Stage one: scale the position by the Q0.16 constants
    always_comb begin
        px_k_next  = pos_x * K_SQRT3_3;
        py_k_next  = pos_y * K_THIRD;
        py_k2_next = pos_y * K_TWO_THIRDS;
    end

    // Stage two: combine and scale by the reciprocal hex size
    always_comb begin
        diff    = (PROD_W+1)'(px_k_reg) - (PROD_W+1)'(py_k_reg);
        inv_s   = $signed({1'b0, inv});
        fx_next = FRAC_W'(diff * inv_s);
        fz_next = FRAC_W'(py_k2_reg * inv_s);
    end

    // Hold each stage unless its load strobe is set
    always_ff @(posedge aclk) begin
        if (ctl.ld0) begin
            px_k_reg  <= px_k_next;
            py_k_reg  <= py_k_next;
            py_k2_reg <= py_k2_next;
        end
        if (ctl.ld1) begin
            fx_reg <= fx_next;
            fz_reg <= fz_next;
        end
    end

    assign frac_x = fx_reg;
    assign frac_z = fz_reg;

endmodule

`default_nettype wire

[src/hgpi_round.sv]
// Round one cube coordinate half away from zero and report the rounding error.
// Depends on hgpi_pkg.
`default_nettype none

module hgpi_round (
    input  wire logic signed [hgpi_pkg::CUBE_W-1:0] coord,
    output hgpi_pkg::hgpi_round_t                   res
);
    import hgpi_pkg::*;

    localparam logic [FRAC_BITS-1:0] HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);

    logic signed [RND_W-2:0]  int_part;
    logic [FRAC_BITS-1:0]     frac;
    logic                     up;

    // Floor split, then step up past the half (ties go away from zero)
    always_comb begin
        int_part = coord[CUBE_W-1:FRAC_BITS];
        frac     = coord[FRAC_BITS-1:0];
        up       = coord[CUBE_W-1] ? (frac > HALF) : (frac >= HALF);
        res.rnd  = RND_W'(int_part) + (up ? RND_W'(1) : RND_W'(0));
        res.err  = up ? (~frac + FRAC_BITS'(1)) : frac;
    end

endmodule

`default_nettype wire

[src/hgpi_cell.sv]
// Clamp an axial pair to the hexagonal board and number its cell row by row.
// Depends on hgpi_pkg.
`default_nettype none

module hgpi_cell #(
    parameter int RADIUS = hgpi_pkg::RADIUS_DEF
) (
    input  wire logic signed [hgpi_pkg::AXIAL_W-1:0] q,
    input  wire logic signed [hgpi_pkg::AXIAL_W-1:0] r,
    output logic [hgpi_pkg::IDX_W-1:0]               cell_index
);
    import hgpi_pkg::*;

    // Clamped coordinates hold up to 2R in magnitude; index math needs 3R(R+1)
    localparam int CW = $clog2(2 * RADIUS + 1) + 1;
    localparam int IW = $clog2(3 * RADIUS * (RADIUS + 1) + 1) + 2;

    localparam logic signed [AXIAL_W-1:0] R_AX   = AXIAL_W'(RADIUS);
    localparam logic signed [CW-1:0]      R_C    = CW'(RADIUS);
    localparam logic signed [IW-1:0]      R_I    = IW'(RADIUS);
    localparam logic signed [IW-1:0]      R3P1   = IW'(3 * RADIUS + 1);
    localparam logic signed [IW-1:0]      R4P2   = IW'(4 * RADIUS + 2);
    localparam logic signed [IW-1:0]      BASE_HI = IW'((RADIUS + 1) * (3 * RADIUS + 2) / 2);
    localparam logic signed [IW-1:0]      ONE_I  = IW'(1);

    logic signed [AXIAL_W-1:0] qc, rc;
    logic signed [CW-1:0]      xc, zc, sum, yc, az, x2;
    logic signed [IW-1:0]      y_i, az_i, x_i, prod_lo, prod_hi, idx_lo, idx_hi, idx_full;

    // Clamp x and z to the board, then y from them
    always_comb begin
        qc  = (q < -R_AX) ? -R_AX : ((q > R_AX) ? R_AX : q);
        rc  = (r < -R_AX) ? -R_AX : ((r > R_AX) ? R_AX : r);
        xc  = CW'(qc);
        zc  = CW'(rc);
        sum = -xc - zc;
        yc  = (sum < -R_C) ? -R_C : ((sum > R_C) ? R_C : sum);
        az  = (zc < 0) ? -zc : zc;
        x2  = -zc - yc;
    end

    // Number the cell: upper half (r <= 0) or lower half
    always_comb begin
        y_i      = IW'(yc);
        az_i     = IW'(az);
        x_i      = IW'(x2);
        prod_lo  = (R3P1 - az_i) * (R_I - az_i);
        prod_hi  = (R4P2 - az_i) * (az_i - ONE_I);
        idx_lo   = (R_I - y_i) + (prod_lo >>> 1);
        idx_hi   = (x_i + R_I) + BASE_HI + (prod_hi >>> 1);
        idx_full = (zc <= 0) ? idx_lo : idx_hi;
        cell_index = idx_full[IDX_W-1:0];
    end

endmodule

`default_nettype wire

[src/hex_grid_pick_index.sv]
// Top level of the hex grid pick index block: six-stage pipeline.
// Depends on hgpi_pkg, hgpi_mult, hgpi_round and hgpi_cell.
//
// Usage:
//   Input channel s_valid/s_ready carries one position (s_pos_x, s_pos_y,
//   signed Q12.4) per beat. Output channel m_valid/m_ready carries the
//   axial pair (m_hex_q, m_hex_r) and the board cell (m_cell_index).
//   cfg_valid/cfg_ready writes inv_hex_size (Q0.16) from cfg_data; cfg_ready
//   is always high. Write it only while no beat is in flight.
//   Throughput: one beat per cycle while m_ready stays high, set by the six pipeline registers
//   (two multiply stages, cube coordinate, rounding, error select, output).
//   Stalls: each stage moves when the one ahead of it is empty or moving,
//   so bubbles close up while m_ready is low; s_ready drops only when all
//   six stages hold a beat. Nothing is dropped or repeated.
//   Reset (aresetn low, synchronous): all stages empty, m_valid low,
//   inv_hex_size back to 2185 (about 1/30 pixel).
`default_nettype none

module hex_grid_pick_index #(
    parameter int RADIUS = hgpi_pkg::RADIUS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [hgpi_pkg::INV_W-1:0]          cfg_data,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [hgpi_pkg::POS_W-1:0]   s_pos_x,
    input  wire logic signed [hgpi_pkg::POS_W-1:0]   s_pos_y,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [hgpi_pkg::HEX_W-1:0]        m_hex_q,
    output logic signed [hgpi_pkg::HEX_W-1:0]        m_hex_r,
    output logic [hgpi_pkg::IDX_W-1:0]               m_cell_index
);
    import hgpi_pkg::*;

    localparam int NST = 6;

    logic [INV_W-1:0]           inv_reg;
    logic [NST-1:0]             vld_reg, vld_next, rdy;
    hgpi_mul_ctl_t              mul_ctl;

    logic signed [FRAC_W-1:0]   frac_x, frac_z;
    logic signed [CUBE_W-1:0]   cx_reg, cy_reg, cz_reg, cx_next, cy_next, cz_next;
    hgpi_round_t                rx, ry, rz;
    hgpi_round_t                rx_reg, ry_reg, rz_reg;
    logic signed [AXIAL_W-1:0]  q_reg, r_reg, q_next, r_next;
    logic [IDX_W-1:0]           idx_comb;
    logic signed [HEX_W-1:0]    hq_reg, hr_reg;
    logic [IDX_W-1:0]           idx_reg;

    // Config register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_reg <= INV_RESET;
        end else if (cfg_valid) begin
            inv_reg <= cfg_data;
        end
    end

    // Stage readiness: a stage loads when empty or when the next one loads
    always_comb begin
        rdy[NST-1] = !vld_reg[NST-1] || m_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        vld_next = {vld_reg[NST-2:0], s_valid};
    end

    // Advance valid bits stage by stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    assign s_ready = rdy[0];

    // Stages one and two: multiplies
    assign mul_ctl.ld0 = rdy[0];
    assign mul_ctl.ld1 = rdy[1];

    hgpi_mult u_mult (
        .aclk   (aclk),
        .ctl    (mul_ctl),
        .pos_x  (s_pos_x),
        .pos_y  (s_pos_y),
        .inv    (inv_reg),
        .frac_x (frac_x),
        .frac_z (frac_z)
    );

    // Stage three: cube coordinates, y from -x - z
    always_comb begin
        cx_next = CUBE_W'(frac_x);
        cz_next = CUBE_W'(frac_z);
        cy_next = -cx_next - cz_next;
    end

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
            cz_reg <= cz_next;
        end
    end

    // Stage four: round each coordinate
    hgpi_round u_round_x (.coord(cx_reg), .res(rx));
    hgpi_round u_round_y (.coord(cy_reg), .res(ry));
    hgpi_round u_round_z (.coord(cz_reg), .res(rz));

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            rx_reg <= rx;
            ry_reg <= ry;
            rz_reg <= rz;
        end
    end

    // Stage five: rebuild the component with the largest rounding error
    always_comb begin
        if (rx_reg.err > ry_reg.err && rx_reg.err > rz_reg.err) begin
            q_next = -AXIAL_W'(ry_reg.rnd) - AXIAL_W'(rz_reg.rnd);
            r_next = AXIAL_W'(rz_reg.rnd);
        end else if (ry_reg.err > rz_reg.err) begin
            q_next = AXIAL_W'(rx_reg.rnd);
            r_next = AXIAL_W'(rz_reg.rnd);
        end else begin
            q_next = AXIAL_W'(rx_reg.rnd);
            r_next = -AXIAL_W'(rx_reg.rnd) - AXIAL_W'(ry_reg.rnd);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    // Stage six: saturate the axial pair, number the board cell
    hgpi_cell #(
        .RADIUS (RADIUS)
    ) u_cell (
        .q          (q_reg),
        .r          (r_reg),
        .cell_index (idx_comb)
    );

    always_ff @(posedge aclk) begin
        if (rdy[5]) begin
            hq_reg  <= sat_hex(q_reg);
            hr_reg  <= sat_hex(r_reg);
            idx_reg <= idx_comb;
        end
    end

    assign m_valid      = vld_reg[NST-1];
    assign m_hex_q      = hq_reg;
    assign m_hex_r      = hr_reg;
    assign m_cell_index = idx_reg;

endmodule

`default_nettype wire

[src/hgpi_chk.sv]
// Port-level checker for the hex grid pick index block, bound to the top level.
// Depends on hgpi_pkg and hex_grid_pick_index_assert.svh.
`default_nettype none
`include "hex_grid_pick_index_assert.svh"

module hgpi_chk #(
    parameter int RADIUS = hgpi_pkg::RADIUS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    input  wire logic                                s_ready,
    input  wire logic                                m_valid,
    input  wire logic                                m_ready,
    input  wire logic signed [hgpi_pkg::HEX_W-1:0]   m_hex_q,
    input  wire logic signed [hgpi_pkg::HEX_W-1:0]   m_hex_r,
    input  wire logic [hgpi_pkg::IDX_W-1:0]          m_cell_index
);
    import hgpi_pkg::*;

    localparam int   LAST     = 3 * RADIUS * (RADIUS + 1);
    localparam logic RANGE_OK = (LAST < (1 << IDX_W));
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(LAST);
    localparam logic [IDX_W-1:0] CENTER_IDX = IDX_W'(LAST / 2);
    localparam logic signed [HEX_W-1:0] ZERO_HEX = '0;

    // Hold a stalled result beat
    `HGPI_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid)
    `HGPI_ASSERT_NXT(a_out_stable, m_valid && !m_ready, $stable(m_hex_q) && $stable(m_hex_r) && $stable(m_cell_index))
    // An empty output stage means the whole pipe can take a beat
    `HGPI_ASSERT_IMP(a_ready_when_empty, !m_valid, s_ready)
    // Cells stay on the board
    `HGPI_ASSERT_IMP(a_idx_range, m_valid && RANGE_OK, m_cell_index <= LAST_IDX)
    // The origin hex is the board center
    `HGPI_ASSERT_IMP(a_center, m_valid && m_hex_q == ZERO_HEX && m_hex_r == ZERO_HEX, m_cell_index == CENTER_IDX)

    // s_valid is part of the watched port set; it has no check of its own here
    logic unused_s_valid;
    assign unused_s_valid = s_valid;

endmodule

bind hex_grid_pick_index hgpi_chk #(
    .RADIUS (RADIUS)
) u_hgpi_chk (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_hex_q      (m_hex_q),
    .m_hex_r      (m_hex_r),
    .m_cell_index (m_cell_index)
);

`default_nettype wire
